FILE: rtl/per_host_traffic_accounting_defines.svh
// Assertion macros shared by the per-host traffic accounting RTL.
`ifndef PER_HOST_TRAFFIC_ACCOUNTING_DEFINES_SVH
`define PER_HOST_TRAFFIC_ACCOUNTING_DEFINES_SVH
`ifndef SYNTHESIS
`define PHTA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("phta: assertion failed");
`define PHTA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("phta: assertion failed");
`else
`define PHTA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PHTA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/phta_pkg.sv
// Shared types and constants of the per-host traffic accounting block.
package phta_pkg;
	localparam int ETYPE_W = 16;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 16;
	localparam int PKT_W = 32;
	localparam int IDX_OUT_W = 7;
	localparam int OUT_BYTE_W = 48;

	localparam logic [ETYPE_W-1:0] IPV4_TYPE = 16'h0800;

	typedef struct packed {
		logic s_ok;
		logic s_new;
		logic d_ok;
		logic d_new;
	} lk_res_t;

	typedef enum logic [2:0] {
		LK_IDLE,
		LK_SCAN,
		LK_ALLOC_SRC,
		LK_ALLOC_DST,
		LK_DONE
	} lk_state_t;

	typedef enum logic [2:0] {
		CN_IDLE,
		CN_RD_SRC,
		CN_RD_DST,
		CN_CALC,
		CN_WR_SRC,
		CN_WR_DST
	} cn_state_t;

	typedef enum logic [2:0] {
		TOP_IDLE,
		TOP_LK_START,
		TOP_LK_WAIT,
		TOP_CN_WAIT,
		TOP_OUT_SRC,
		TOP_OUT_DST
	} top_state_t;
endpackage

FILE: rtl/phta_desc_if.sv
// Packet descriptor channel carrying one frame per beat.
interface phta_desc_if;
	import phta_pkg::*;
	logic valid;
	logic ready;
	logic [ETYPE_W-1:0] eth_type;
	logic [ADDR_W-1:0] src_addr;
	logic [ADDR_W-1:0] dst_addr;
	logic [LEN_W-1:0] frame_length;

	modport source (output valid, eth_type, src_addr, dst_addr, frame_length,
		input ready);
	modport sink (input valid, eth_type, src_addr, dst_addr, frame_length,
		output ready);
endinterface

FILE: rtl/phta_result_if.sv
// Host result channel carrying one host entry report per beat.
interface phta_result_if;
	import phta_pkg::*;
	logic valid;
	logic ready;
	logic is_destination;
	logic accepted;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [ADDR_W-1:0] host_addr;
	logic [OUT_BYTE_W-1:0] tx_total;
	logic [OUT_BYTE_W-1:0] rx_total;
	logic [PKT_W-1:0] packet_total;
	logic [LEN_W-1:0] peak_length;
	logic last;

	modport source (output valid, is_destination, accepted, entry_index, host_addr,
		tx_total, rx_total, packet_total, peak_length, last, input ready);
	modport sink (input valid, is_destination, accepted, entry_index, host_addr,
		tx_total, rx_total, packet_total, peak_length, last, output ready);
endinterface

FILE: rtl/phta_lookup.sv
// Host address memory with sequential scan and slot allocation.
`include "per_host_traffic_accounting_defines.svh"
module phta_lookup #(
	parameter int TABLE_DEPTH = 128
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [phta_pkg::ADDR_W-1:0] src,
	input logic [phta_pkg::ADDR_W-1:0] dst,
	output logic done,
	output phta_pkg::lk_res_t res,
	output logic [$clog2(TABLE_DEPTH)-1:0] s_slot,
	output logic [$clog2(TABLE_DEPTH)-1:0] d_slot
);
	import phta_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	lk_state_t state_q, state_d;
	logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] rdata_s1;
	logic rd_vld_s1;
	logic [SW-1:0] rd_idx_s1;
	logic [CW-1:0] used_q, idx_q;
	logic s_hit_q, d_hit_q, s_ok_q, d_ok_q, s_new_q, d_new_q;
	logic [SW-1:0] s_slot_q, d_slot_q;
	logic room, issue, scan_end, same_addr;
	logic wr_en;
	logic [SW-1:0] wr_idx;
	logic [ADDR_W-1:0] wr_data;

	assign room = used_q != FULL;
	assign same_addr = src == dst;
	assign issue = (state_q == LK_SCAN) && (idx_q < used_q) && !(s_hit_q && d_hit_q);
	assign scan_end = (state_q == LK_SCAN) && !issue && !rd_vld_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			LK_IDLE: begin
				if (start) begin
					state_d = LK_SCAN;
				end
			end
			LK_SCAN: begin
				if (scan_end) begin
					state_d = LK_ALLOC_SRC;
				end
			end
			LK_ALLOC_SRC: state_d = LK_ALLOC_DST;
			LK_ALLOC_DST: state_d = LK_DONE;
			LK_DONE: state_d = LK_IDLE;
			default: state_d = LK_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = used_q[SW-1:0];
		wr_data = src;
		done = 1'b0;
		case (state_q)
			LK_ALLOC_SRC: wr_en = !s_hit_q && room;
			LK_ALLOC_DST: begin
				wr_en = !d_hit_q && !(same_addr && s_ok_q) && room;
				wr_data = dst;
			end
			LK_DONE: done = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= wr_data;
		end
		if (issue) begin
			rdata_s1 <= addr_mem[idx_q[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LK_IDLE;
			used_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			s_hit_q <= 1'b0;
			d_hit_q <= 1'b0;
			s_ok_q <= 1'b0;
			d_ok_q <= 1'b0;
			s_new_q <= 1'b0;
			d_new_q <= 1'b0;
			s_slot_q <= '0;
			d_slot_q <= '0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= issue;
			rd_idx_s1 <= idx_q[SW-1:0];
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				LK_IDLE: begin
					if (start) begin
						idx_q <= '0;
						s_hit_q <= 1'b0;
						d_hit_q <= 1'b0;
					end
				end
				LK_SCAN: begin
					if (rd_vld_s1 && rdata_s1 == src && !s_hit_q) begin
						s_hit_q <= 1'b1;
						s_slot_q <= rd_idx_s1;
					end
					if (rd_vld_s1 && rdata_s1 == dst && !d_hit_q) begin
						d_hit_q <= 1'b1;
						d_slot_q <= rd_idx_s1;
					end
				end
				LK_ALLOC_SRC: begin
					s_ok_q <= s_hit_q || room;
					s_new_q <= !s_hit_q;
					if (!s_hit_q) begin
						s_slot_q <= used_q[SW-1:0];
						if (room) begin
							used_q <= used_q + CW'(1);
						end
					end
				end
				LK_ALLOC_DST: begin
					if (d_hit_q) begin
						d_ok_q <= 1'b1;
						d_new_q <= 1'b0;
					end else if (same_addr && s_ok_q) begin
						d_ok_q <= 1'b1;
						d_new_q <= s_new_q;
						d_slot_q <= s_slot_q;
					end else begin
						d_ok_q <= room;
						d_new_q <= 1'b1;
						d_slot_q <= used_q[SW-1:0];
						if (room) begin
							used_q <= used_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res = '{s_ok: s_ok_q, s_new: s_new_q, d_ok: d_ok_q, d_new: d_new_q};
	assign s_slot = s_slot_q;
	assign d_slot = d_slot_q;

	`PHTA_ASSERT_NEXT(a_used_only_in_alloc, clk, arst_n, state_q != LK_ALLOC_SRC && state_q != LK_ALLOC_DST, $stable(used_q))
	`PHTA_ASSERT_IMPL(a_src_slot_allocated, clk, arst_n, state_q == LK_DONE && s_ok_q, CW'(s_slot_q) < used_q)
	`PHTA_ASSERT_IMPL(a_same_host_same_slot, clk, arst_n, state_q == LK_DONE && s_ok_q && same_addr, d_ok_q && d_slot_q == s_slot_q)
endmodule

FILE: rtl/phta_counters.sv
// Per-host counter memory with read, update and write-back sequencing.
module phta_counters #(
	parameter int TABLE_DEPTH = 128,
	parameter int BYTE_COUNTER_WIDTH = 48
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [phta_pkg::LEN_W-1:0] len,
	input phta_pkg::lk_res_t res,
	input logic [$clog2(TABLE_DEPTH)-1:0] s_slot,
	input logic [$clog2(TABLE_DEPTH)-1:0] d_slot,
	output logic done,
	output logic [2*BYTE_COUNTER_WIDTH+phta_pkg::PKT_W+phta_pkg::LEN_W-1:0] s_entry,
	output logic [2*BYTE_COUNTER_WIDTH+phta_pkg::PKT_W+phta_pkg::LEN_W-1:0] d_entry
);
	import phta_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int BW = BYTE_COUNTER_WIDTH;

	typedef struct packed {
		logic [BW-1:0] tx;
		logic [BW-1:0] rx;
		logic [PKT_W-1:0] pkt;
		logic [LEN_W-1:0] peak;
	} entry_t;

	cn_state_t state_q, state_d;
	entry_t cnt_mem [TABLE_DEPTH];
	entry_t rdata_s1, s_base_q, s_ent_q, d_ent_q, d_base, s_calc, d_calc;
	logic rd_en, wr_en, same;
	logic [SW-1:0] rd_idx, wr_idx;
	entry_t wr_data;
	logic [BW-1:0] len_b;

	assign same = res.s_ok && res.d_ok && (s_slot == d_slot);
	assign len_b = BW'(len);
	assign d_base = res.d_new ? '0 : rdata_s1;

	always_comb begin
		s_calc.tx = s_base_q.tx + len_b;
		s_calc.rx = same ? s_base_q.rx + len_b : s_base_q.rx;
		s_calc.pkt = s_base_q.pkt + (same ? PKT_W'(2) : PKT_W'(1));
		s_calc.peak = (len > s_base_q.peak) ? len : s_base_q.peak;
		if (same) begin
			d_calc = s_calc;
		end else begin
			d_calc.tx = d_base.tx;
			d_calc.rx = d_base.rx + len_b;
			d_calc.pkt = d_base.pkt + PKT_W'(1);
			d_calc.peak = (len > d_base.peak) ? len : d_base.peak;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CN_IDLE: begin
				if (start) begin
					state_d = CN_RD_SRC;
				end
			end
			CN_RD_SRC: state_d = CN_RD_DST;
			CN_RD_DST: state_d = CN_CALC;
			CN_CALC: state_d = CN_WR_SRC;
			CN_WR_SRC: state_d = CN_WR_DST;
			CN_WR_DST: state_d = CN_IDLE;
			default: state_d = CN_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		rd_idx = s_slot;
		wr_en = 1'b0;
		wr_idx = s_slot;
		wr_data = s_ent_q;
		done = 1'b0;
		case (state_q)
			CN_RD_SRC: rd_en = 1'b1;
			CN_RD_DST: begin
				rd_en = 1'b1;
				rd_idx = d_slot;
			end
			CN_WR_SRC: wr_en = res.s_ok;
			CN_WR_DST: begin
				wr_en = res.d_ok;
				wr_idx = d_slot;
				wr_data = d_ent_q;
				done = 1'b1;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= cnt_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CN_IDLE;
			s_base_q <= '0;
			s_ent_q <= '0;
			d_ent_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CN_RD_DST) begin
				s_base_q <= res.s_new ? '0 : rdata_s1;
			end
			if (state_q == CN_CALC) begin
				s_ent_q <= s_calc;
				d_ent_q <= d_calc;
			end
		end
	end

	assign s_entry = s_ent_q;
	assign d_entry = d_ent_q;
endmodule

FILE: rtl/per_host_traffic_accounting.sv
// Top level of the per-host traffic accounting table.
// An IPv4 frame passes the lookup, the counter update and two result beats that wait on
// result ready: the address memory is scanned one slot per cycle and the scan stops once
// both hosts are found. The counter update reads the source and destination entries,
// calculates and writes both back; a new beat is taken in the cycle after the last result.
// A non-IPv4 beat is dropped. Reset clears the slot count and control state.
`include "per_host_traffic_accounting_defines.svh"
module per_host_traffic_accounting #(
	parameter int TABLE_DEPTH = 128,
	parameter int BYTE_COUNTER_WIDTH = 48
) (
	input logic clk,
	input logic arst_n,
	phta_desc_if.sink desc,
	phta_result_if.source result
);
	import phta_pkg::*;

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int BW = BYTE_COUNTER_WIDTH;
	localparam int ENT_W = 2 * BW + PKT_W + LEN_W;
	localparam int PKT_LSB = LEN_W;
	localparam int RX_LSB = LEN_W + PKT_W;
	localparam int TX_LSB = LEN_W + PKT_W + BW;

	top_state_t state_q, state_d;
	logic [ADDR_W-1:0] src_q, dst_q;
	logic [LEN_W-1:0] len_q;
	logic desc_acc, is_ipv4;
	logic lk_start, lk_done, cn_done;
	lk_res_t lk_res;
	logic [SW-1:0] s_slot, d_slot, slot;
	logic [ENT_W-1:0] s_entry, d_entry, ent;
	logic sel_dst, ok;
	logic [63:0] tx_ext, rx_ext;
	logic [15:0] slot_ext;

	assign desc_acc = desc.valid && desc.ready;
	assign is_ipv4 = desc.eth_type == IPV4_TYPE;

	phta_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_lookup (
		.clk(clk),
		.arst_n(arst_n),
		.start(lk_start),
		.src(src_q),
		.dst(dst_q),
		.done(lk_done),
		.res(lk_res),
		.s_slot(s_slot),
		.d_slot(d_slot)
	);

	phta_counters #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.BYTE_COUNTER_WIDTH(BYTE_COUNTER_WIDTH)
	) u_counters (
		.clk(clk),
		.arst_n(arst_n),
		.start(lk_done),
		.len(len_q),
		.res(lk_res),
		.s_slot(s_slot),
		.d_slot(d_slot),
		.done(cn_done),
		.s_entry(s_entry),
		.d_entry(d_entry)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_IDLE: begin
				if (desc_acc && is_ipv4) begin
					state_d = TOP_LK_START;
				end
			end
			TOP_LK_START: state_d = TOP_LK_WAIT;
			TOP_LK_WAIT: begin
				if (lk_done) begin
					state_d = TOP_CN_WAIT;
				end
			end
			TOP_CN_WAIT: begin
				if (cn_done) begin
					state_d = TOP_OUT_SRC;
				end
			end
			TOP_OUT_SRC: begin
				if (result.ready) begin
					state_d = TOP_OUT_DST;
				end
			end
			TOP_OUT_DST: begin
				if (result.ready) begin
					state_d = TOP_IDLE;
				end
			end
			default: state_d = TOP_IDLE;
		endcase
	end

	always_comb begin
		desc.ready = state_q == TOP_IDLE;
		lk_start = state_q == TOP_LK_START;
		result.valid = (state_q == TOP_OUT_SRC) || (state_q == TOP_OUT_DST);
		sel_dst = state_q == TOP_OUT_DST;
		ok = sel_dst ? lk_res.d_ok : lk_res.s_ok;
		ent = sel_dst ? d_entry : s_entry;
		slot = sel_dst ? d_slot : s_slot;
		tx_ext = 64'(ent[TX_LSB +: BW]);
		rx_ext = 64'(ent[RX_LSB +: BW]);
		slot_ext = 16'(slot);
		result.is_destination = sel_dst;
		result.last = sel_dst;
		result.accepted = ok;
		result.host_addr = sel_dst ? dst_q : src_q;
		result.entry_index = ok ? slot_ext[IDX_OUT_W-1:0] : '0;
		result.tx_total = ok ? tx_ext[OUT_BYTE_W-1:0] : '0;
		result.rx_total = ok ? rx_ext[OUT_BYTE_W-1:0] : '0;
		result.packet_total = ok ? ent[PKT_LSB +: PKT_W] : '0;
		result.peak_length = ok ? ent[LEN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			src_q <= '0;
			dst_q <= '0;
			len_q <= '0;
		end else begin
			state_q <= state_d;
			if (desc_acc) begin
				src_q <= desc.src_addr;
				dst_q <= desc.dst_addr;
				len_q <= desc.frame_length;
			end
		end
	end

	`PHTA_ASSERT_IMPL(a_result_after_count, clk, arst_n, $rose(result.valid), $past(cn_done))
	`PHTA_ASSERT_IMPL(a_lookup_done_awaited, clk, arst_n, lk_done, state_q == TOP_LK_WAIT)
	`PHTA_ASSERT_NEXT(a_last_beat_frees_input, clk, arst_n, result.valid && result.ready && result.last, desc.ready)
endmodule

FILE: tb/sv/phta_host_tracker.sv
// Monitor that predicts the host table reports from accepted frames and checks every result beat.
module phta_host_tracker (
	input logic clk,
	input logic arst_n,
	phta_desc_if desc,
	phta_result_if result,
	output int mismatch_count,
	output int pending_reports,
	output int reports_checked,
	output int rejected_reports
);
	timeunit 1ns;
	timeprecision 1ps;
	import phta_pkg::*;

	localparam int SLOTS = 128;
	localparam int BYTE_W = 48;

	typedef struct packed {
		logic is_dst;
		logic ok;
		logic [IDX_OUT_W-1:0] idx;
		logic [ADDR_W-1:0] addr;
		logic [OUT_BYTE_W-1:0] tx;
		logic [OUT_BYTE_W-1:0] rx;
		logic [PKT_W-1:0] pkts;
		logic [LEN_W-1:0] peak;
		logic last_beat;
	} host_report_t;

	logic [ADDR_W-1:0] slot_addr [SLOTS];
	logic [BYTE_W-1:0] slot_tx [SLOTS];
	logic [BYTE_W-1:0] slot_rx [SLOTS];
	logic [PKT_W-1:0] slot_pkts [SLOTS];
	logic [LEN_W-1:0] slot_peak [SLOTS];
	int slots_used;
	host_report_t expected_reports [$];

	function automatic int claim_slot(logic [ADDR_W-1:0] addr);
		int found = -1;
		for (int i = 0; i < slots_used; i++) begin
			if (found < 0 && slot_addr[i] == addr) begin
				found = i;
			end
		end
		if (found < 0 && slots_used < SLOTS) begin
			found = slots_used;
			slot_addr[found] = addr;
			slot_tx[found] = '0;
			slot_rx[found] = '0;
			slot_pkts[found] = '0;
			slot_peak[found] = '0;
			slots_used++;
		end
		return found;
	endfunction

	function automatic void bump_slot(int slot, logic [LEN_W-1:0] len, logic as_sender);
		if (slot < 0) begin
			return;
		end
		if (as_sender) begin
			slot_tx[slot] = slot_tx[slot] + BYTE_W'(len);
		end else begin
			slot_rx[slot] = slot_rx[slot] + BYTE_W'(len);
		end
		slot_pkts[slot] = slot_pkts[slot] + PKT_W'(1);
		if (len > slot_peak[slot]) begin
			slot_peak[slot] = len;
		end
	endfunction

	function automatic host_report_t report_for(int slot, logic [ADDR_W-1:0] addr, logic dst);
		host_report_t r;
		r = '0;
		r.is_dst = dst;
		r.last_beat = dst;
		r.addr = addr;
		if (slot >= 0) begin
			r.ok = 1'b1;
			r.idx = slot[IDX_OUT_W-1:0];
			r.tx = OUT_BYTE_W'(slot_tx[slot]);
			r.rx = OUT_BYTE_W'(slot_rx[slot]);
			r.pkts = slot_pkts[slot];
			r.peak = slot_peak[slot];
		end
		return r;
	endfunction

	function automatic void predict_frame(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
		logic [LEN_W-1:0] len);
		int s;
		int d;
		s = claim_slot(src);
		d = claim_slot(dst);
		bump_slot(s, len, 1'b1);
		bump_slot(d, len, 1'b0);
		expected_reports.push_back(report_for(s, src, 1'b0));
		expected_reports.push_back(report_for(d, dst, 1'b1));
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("[%0t] result beat %0d: %s expected %h, got %h",
					$realtime, reports_checked, field, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		host_report_t want;
		if (!arst_n) begin
			slots_used = 0;
			expected_reports.delete();
			mismatch_count = 0;
			pending_reports = 0;
			reports_checked = 0;
			rejected_reports = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] result beat with no frame pending: host %h",
							$realtime, result.host_addr);
					end
				end else begin
					want = expected_reports.pop_front();
					check_field("is_destination", 64'(want.is_dst),
						64'(result.is_destination));
					check_field("accepted", 64'(want.ok), 64'(result.accepted));
					check_field("entry_index", 64'(want.idx), 64'(result.entry_index));
					check_field("host_addr", 64'(want.addr), 64'(result.host_addr));
					check_field("tx_total", 64'(want.tx), 64'(result.tx_total));
					check_field("rx_total", 64'(want.rx), 64'(result.rx_total));
					check_field("packet_total", 64'(want.pkts), 64'(result.packet_total));
					check_field("peak_length", 64'(want.peak), 64'(result.peak_length));
					check_field("last", 64'(want.last_beat), 64'(result.last));
					reports_checked++;
					if (!want.ok) begin
						rejected_reports++;
					end
				end
			end
			if (desc.valid && desc.ready && desc.eth_type == IPV4_TYPE) begin
				predict_frame(desc.src_addr, desc.dst_addr, desc.frame_length);
			end
			pending_reports = expected_reports.size();
		end
	end
endmodule

FILE: tb/sv/per_host_traffic_accounting_tb.sv
// Top of the per-host traffic accounting testbench: clock, reset, frame stimulus and verdict.
module per_host_traffic_accounting_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import phta_pkg::*;

	localparam int POOL_SIZE = 200;
	localparam int RANDOM_FRAMES = 1230;
	localparam int CALM_FRAMES = 150;

	logic clk;
	logic arst_n;

	phta_desc_if desc_if ();
	phta_result_if result_if ();

	int mismatch_count;
	int pending_reports;
	int reports_checked;
	int rejected_reports;

	logic idle_off;
	int stall_left;
	int run_left;
	logic [ADDR_W-1:0] host_pool [POOL_SIZE];
	int frames_sent;
	int noise_sent;

	per_host_traffic_accounting u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.desc(desc_if),
		.result(result_if)
	);

	phta_host_tracker u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.desc(desc_if),
		.result(result_if),
		.mismatch_count(mismatch_count),
		.pending_reports(pending_reports),
		.reports_checked(reports_checked),
		.rejected_reports(rejected_reports)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic send_frame(input logic [ETYPE_W-1:0] etype, input logic [ADDR_W-1:0] src,
		input logic [ADDR_W-1:0] dst, input logic [LEN_W-1:0] len);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			desc_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		desc_if.valid <= 1'b1;
		desc_if.eth_type <= etype;
		desc_if.src_addr <= src;
		desc_if.dst_addr <= dst;
		desc_if.frame_length <= len;
		@(posedge clk);
		while (!desc_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (etype == IPV4_TYPE) begin
			frames_sent++;
		end else begin
			noise_sent++;
		end
	endtask

	function automatic logic [ADDR_W-1:0] pick_host(int window);
		if ($urandom_range(0, 19) == 0) begin
			return $urandom;
		end
		return host_pool[$urandom_range(0, window)];
	endfunction

	initial begin
		result_if.ready = 1'b0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else if (!idle_off) begin
					stall_left = $urandom_range(1, 17);
					run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
						: $urandom_range(0, 15);
				end
			end
		end
	end

	initial begin
		logic [ETYPE_W-1:0] etype;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [LEN_W-1:0] len;
		int window;
		int rnd_frames;

		arst_n = 1'b0;
		idle_off = 1'b0;
		frames_sent = 0;
		noise_sent = 0;
		rnd_frames = 0;
		desc_if.valid = 1'b0;
		desc_if.eth_type = '0;
		desc_if.src_addr = '0;
		desc_if.dst_addr = '0;
		desc_if.frame_length = '0;
		for (int k = 0; k < POOL_SIZE; k++) begin
			host_pool[k] = $urandom;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(IPV4_TYPE, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
		send_frame(IPV4_TYPE, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
		send_frame(16'h0000, 32'h0A00_0001, 32'h0A00_0002, 16'd64);
		send_frame(16'hFFFF, 32'h0A00_0003, 32'h0A00_0004, 16'd1500);
		send_frame(16'h0801, 32'h0A00_0005, 32'h0000_0000, 16'd100);
		send_frame(16'h0008, 32'hC0A8_0001, 32'hC0A8_0002, 16'd60);
		send_frame(16'h86DD, 32'h0A00_0006, 32'h0A00_0007, 16'd1280);
		send_frame(IPV4_TYPE, host_pool[0], host_pool[0], 16'd1500);
		send_frame(IPV4_TYPE, host_pool[0], host_pool[0], 16'd64);
		send_frame(IPV4_TYPE, host_pool[0], 32'h0000_0000, 16'hFFFF);
		send_frame(IPV4_TYPE, host_pool[1], host_pool[2], 16'd1);
		send_frame(16'h0806, 32'hC0A8_0101, 32'hC0A8_01FF, 16'd42);
		send_frame(IPV4_TYPE, host_pool[2], host_pool[1], 16'hFFFE);
		send_frame(IPV4_TYPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
		send_frame(16'h8100, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_frame(IPV4_TYPE, host_pool[1], 32'hFFFF_FFFF, 16'd512);

		while (rnd_frames < RANDOM_FRAMES) begin
			idle_off = (rnd_frames >= RANDOM_FRAMES - CALM_FRAMES);
			if ($urandom_range(0, 6) == 0) begin
				etype = ETYPE_W'($urandom);
				if ($urandom_range(0, 1) == 0) begin
					etype = IPV4_TYPE ^ (16'h0001 << $urandom_range(0, 15));
				end
				if (etype == IPV4_TYPE) begin
					etype[0] = ~etype[0];
				end
				send_frame(etype, $urandom, $urandom, LEN_W'($urandom));
			end else begin
				window = 16 + rnd_frames / 8;
				if (window > POOL_SIZE - 1) begin
					window = POOL_SIZE - 1;
				end
				src = pick_host(window);
				dst = ($urandom_range(0, 15) == 0) ? src : pick_host(window);
				case ($urandom_range(0, 7))
					0: len = '0;
					1: len = '1;
					2, 3: len = LEN_W'($urandom_range(64, 1518));
					default: len = LEN_W'($urandom);
				endcase
				send_frame(IPV4_TYPE, src, dst, len);
				rnd_frames++;
			end
		end
		desc_if.valid <= 1'b0;

		wait (pending_reports == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d IPv4 frames and %0d ignored beats of other types.",
			frames_sent, noise_sent);
		$display("Checked %0d host reports, %0d of them refused by a full table.",
			reports_checked, rejected_reports);
		if (mismatch_count == 0 && pending_reports == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Run timed out with %0d reports outstanding.", pending_reports);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
